>>> hw/rtl/csp_pkg.sv
// Shared types and codes of the color string parser.
package csp_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FORM = 2'd1;
	localparam logic [1:0] ST_NUM  = 2'd2;

	// Width of the result word on the output port
	localparam int unsigned RES_DATA_W = 40;

	// One input character with its end marker
	typedef struct packed {
		logic       last;
		logic [7:0] ch;
	} item_t;

	// One parsed color result
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] alpha;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} result_t;

endpackage

>>> hw/rtl/color_string_parser_top.sv
// Top level of the color string parser.
// Takes one character per word on the slave side and gives one RGBA word on
// the master side for each character marked by s_tlast; other characters give
// no output. Throughput is one character per clock unless a final character
// waits on a full result register. A result passes the input register and
// then the result register. The per-character state update (prefix match,
// decimal accumulate, hex nibble pairing) is combinational between the two
// registers. While a result waits to be taken, the characters of the next
// string keep flowing; only its final character holds in the input register
// until the result register frees up.
module color_string_parser_top
	import csp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] ch
	input  logic                  s_tlast,  // last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [RES_DATA_W-1:0] m_tdata   // [7:0] red, [15:8] green, [23:16] blue,
	                                        // [31:24] alpha, [33:32] status, rest zero
);

	item_t   in_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	logic    step;
	logic    res_valid;
	result_t res;

	assign in_item = '{last: s_tlast, ch: s_tdata};

	// Only a final character needs room in the result register
	assign step = advance || !item_s1.last;

	csp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (step),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	csp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && step),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	csp_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> hw/rtl/csp_in_stage.sv
// Input register stage of the color string parser.
module csp_in_stage
	import csp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  item_t      in_item,
	input  logic       advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic valid_q;

	// Accept a new word whenever the stage is empty or drains this cycle
	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Hold the payload until the next word arrives
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

>>> hw/rtl/csp_core.sv
// Per-character parse state and result logic of the color string parser.
module csp_core
	import csp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output logic    res_valid,
	output result_t res
);

	typedef enum logic [3:0] {
		M_START, M_R, M_RG, M_RGB, M_RGBA, M_DEC3, M_DEC4, M_HEX, M_BAD
	} mode_t;

	mode_t      mode_q,  n_mode;
	logic [3:0] cpos_q,  n_cpos;
	logic [7:0] comp_q [4];
	logic [7:0] n_comp [4];
	logic [2:0] tidx_q,  n_tidx;
	logic [7:0] tval_q,  n_tval;
	logic [1:0] phase_q, n_phase;
	logic       neg_q,   n_neg;
	logic [3:0] hnib_q,  n_hnib;
	logic       err_q,   n_err;
	logic       seen_q,  n_seen;

	logic [7:0] c;
	logic       is_dec;
	logic [2:0] limit;
	logic       digit;
	logic       space;
	logic [4:0] hexv;
	logic       do_finish;
	logic       do_dec;
	logic [3:0] p;
	logic [7:0] v;
	logic [7:0] tok;

	// Hex digit value, bit 4 set when the character is a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'd0;
		if (ch inside {["0":"9"]}) begin
			r = {1'b1, 4'(ch - 8'h30)};
		end else if (ch inside {["a":"f"]}) begin
			r = {1'b1, 4'(ch - 8'h57)};
		end else if (ch inside {["A":"F"]}) begin
			r = {1'b1, 4'(ch - 8'h37)};
		end
		return r;
	endfunction

	assign c      = item.ch;
	assign is_dec = (mode_q == M_DEC3) || (mode_q == M_DEC4);
	assign limit  = (mode_q == M_DEC3) ? 3'd3 : 3'd4;
	assign digit  = c inside {["0":"9"]};
	assign space  = (c == 8'd32) || (c inside {[8'd9:8'd13]});
	assign hexv   = hex_value(c);
	assign p      = cpos_q;
	assign tok    = neg_q ? 8'(8'd0 - tval_q) : tval_q;

	// A comma or the end of a seen token closes it; other characters extend it
	assign do_finish = is_dec && ((!item.last && c == ",") || (item.last && seen_q));
	assign do_dec    = is_dec && !item.last && c != ",";

	// Next state and the result of this character
	always_comb begin
		n_mode  = mode_q;
		n_cpos  = cpos_q;
		n_comp  = comp_q;
		n_tidx  = tidx_q;
		n_tval  = tval_q;
		n_phase = phase_q;
		n_neg   = neg_q;
		n_hnib  = hnib_q;
		n_err   = err_q;
		n_seen  = seen_q;
		v       = 8'd0;
		res     = '0;
		res.status = ST_FORM;

		// Prefix recognition
		if (!item.last) begin
			case (mode_q)
				M_START: begin
					if (c == "#") n_mode = M_HEX;
					else if (c == "r") n_mode = M_R;
					else n_mode = M_BAD;
				end
				M_R:    n_mode = (c == "g") ? M_RG : M_BAD;
				M_RG:   n_mode = (c == "b") ? M_RGB : M_BAD;
				M_RGB:  n_mode = (c == "a") ? M_RGBA : M_DEC3;
				M_RGBA: n_mode = M_DEC4;
				default: ;
			endcase
		end

		// Close a decimal token
		if (do_finish) begin
			if (tidx_q < limit) begin
				if (phase_q < 2'd2) n_err = 1'b1;
				else n_comp[tidx_q[1:0]] = tok;
			end
			if (tidx_q != 3'd7) n_tidx = tidx_q + 3'd1;
			n_tval  = 8'd0;
			n_phase = 2'd0;
			n_neg   = 1'b0;
			n_seen  = 1'b0;
		end

		// Extend a decimal token
		if (do_dec) begin
			n_seen = 1'b1;
			if (tidx_q < limit) begin
				case (phase_q)
					2'd0: begin
						if (space) begin
						end else if (c == "+" || c == "-") begin
							n_neg   = (c == "-");
							n_phase = 2'd1;
						end else if (digit) begin
							n_tval  = 8'(c - 8'h30);
							n_phase = 2'd2;
						end else begin
							n_err   = 1'b1;
							n_phase = 2'd3;
						end
					end
					2'd1: begin
						if (digit) begin
							n_tval  = 8'(c - 8'h30);
							n_phase = 2'd2;
						end else begin
							n_err   = 1'b1;
							n_phase = 2'd3;
						end
					end
					2'd2: begin
						if (digit) n_tval = 8'({tval_q, 3'd0} + {tval_q, 1'b0} + (c - 8'h30));
						else n_phase = 2'd3;
					end
					default: ;
				endcase
			end
		end

		// Hex payload: even position latches a lead, odd position stores a byte
		if (mode_q == M_HEX) begin
			if (cpos_q != 4'd15) n_cpos = cpos_q + 4'd1;
			if (!p[3]) begin
				if (!p[0]) begin
					if (hexv[4]) begin
						n_phase = 2'd1;
						n_hnib  = hexv[3:0];
					end else if (space || c == "+") begin
						n_phase = 2'd2;
					end else if (c == "-") begin
						n_phase = 2'd3;
					end else begin
						n_phase = 2'd0;
						n_err   = 1'b1;
					end
				end else begin
					case (phase_q)
						2'd1: v = hexv[4] ? {hnib_q, hexv[3:0]} : {4'd0, hnib_q};
						2'd2: begin
							if (hexv[4]) v = {4'd0, hexv[3:0]};
							else n_err = 1'b1;
						end
						2'd3: begin
							if (hexv[4]) v = 8'(8'd0 - {4'd0, hexv[3:0]});
							else n_err = 1'b1;
						end
						default: n_err = 1'b1;
					endcase
					n_comp[p[2:1]] = v;
				end
			end
		end

		// Result on the final character
		if (item.last) begin
			case (mode_q)
				M_RG: begin
					if (c == "b") res.status = ST_NUM;
				end
				M_RGB: begin
					if (c == "a") begin
						res.status = ST_NUM;
					end else begin
						res.status = ST_OK;
						res.alpha  = 8'hFF;
					end
				end
				M_RGBA: res.status = ST_OK;
				M_DEC3, M_DEC4: begin
					if (n_err) begin
						res.status = ST_NUM;
					end else begin
						res.status = ST_OK;
						res.red    = n_comp[0];
						res.green  = n_comp[1];
						res.blue   = n_comp[2];
						res.alpha  = (mode_q == M_DEC3) ? 8'hFF : n_comp[3];
					end
				end
				M_HEX: begin
					if (n_cpos != 4'd6 && n_cpos != 4'd8) begin
						res.status = ST_FORM;
					end else if (n_err) begin
						res.status = ST_NUM;
					end else begin
						res.status = ST_OK;
						res.red    = n_comp[0];
						res.green  = n_comp[1];
						res.blue   = n_comp[2];
						res.alpha  = (n_cpos == 4'd6) ? 8'hFF : n_comp[3];
					end
				end
				default: ;
			endcase

			// Return to the start of a string
			n_mode  = M_START;
			n_cpos  = 4'd0;
			n_comp  = '{default: 8'd0};
			n_tidx  = 3'd0;
			n_tval  = 8'd0;
			n_phase = 2'd0;
			n_neg   = 1'b0;
			n_hnib  = 4'd0;
			n_err   = 1'b0;
			n_seen  = 1'b0;
		end
	end

	assign res_valid = en && item.last;

	// Advance parse state by one character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			cpos_q  <= 4'd0;
			comp_q  <= '{default: 8'd0};
			tidx_q  <= 3'd0;
			tval_q  <= 8'd0;
			phase_q <= 2'd0;
			neg_q   <= 1'b0;
			hnib_q  <= 4'd0;
			err_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (en) begin
			mode_q  <= n_mode;
			cpos_q  <= n_cpos;
			comp_q  <= n_comp;
			tidx_q  <= n_tidx;
			tval_q  <= n_tval;
			phase_q <= n_phase;
			neg_q   <= n_neg;
			hnib_q  <= n_hnib;
			err_q   <= n_err;
			seen_q  <= n_seen;
		end
	end

endmodule

>>> hw/rtl/csp_out_stage.sv
// Output result register of the color string parser.
module csp_out_stage
	import csp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  result_t               res,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [RES_DATA_W-1:0] out_data
);

	logic    valid_q;
	result_t res_q;

	// The parse stage may move when the slot is free or being emptied
	assign advance   = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = {(RES_DATA_W - $bits(result_t))'(0), res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk) begin
		if (advance && load) begin
			res_q <= res;
		end
	end

endmodule

>>> hw/rtl/csp_checker.sv
// Port-level checks of the color string parser, bound to the top level.
module csp_checker
	import csp_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [7:0]            s_tdata,
	input logic                  s_tlast,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [RES_DATA_W-1:0] m_tdata
);

	logic [2:0] pend_q;
	logic       in_end;
	logic       out_take;

	assign in_end   = s_tvalid && s_tready && s_tlast;
	assign out_take = m_tvalid && m_tready;

	// Count strings ended at the input and not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'd0, in_end} - {2'd0, out_take};
		end
	end

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// Every result answers an ended string
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 3'd0)
		else $error("result without a final character");

	// Failed parses carry zero color
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == 32'd0)
		else $error("failed parse with nonzero color");

	// Status and padding stay in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[33:32] != 2'd3 && m_tdata[RES_DATA_W-1:34] == '0)
		else $error("bad status or padding");

endmodule

bind color_string_parser_top csp_checker u_csp_checker (.*);

>>> bench/tb_color_string_parser_top.sv
// Testbench for the color string parser: streams color strings and checks each RGBA word.
`timescale 1ns / 1ps

module tb_color_string_parser_top;
	import csp_pkg::*;

	localparam int TARGET_CHARS = 1550;

	// Parser form codes
	typedef enum logic [3:0] {
		FM_START, FM_R, FM_RG, FM_RGB, FM_RGBA, FM_DEC3, FM_DEC4, FM_HEX, FM_BAD
	} form_t;

	// Decimal token phases
	localparam logic [1:0] TP_LEAD   = 2'd0;
	localparam logic [1:0] TP_SIGN   = 2'd1;
	localparam logic [1:0] TP_DIGITS = 2'd2;
	localparam logic [1:0] TP_DONE   = 2'd3;

	// Hex pair phases, kept in the same phase register
	localparam logic [1:0] HX_NONE  = 2'd0;
	localparam logic [1:0] HX_HIGH  = 2'd1;
	localparam logic [1:0] HX_PLAIN = 2'd2;
	localparam logic [1:0] HX_NEG   = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = 8'd0;  // [7:0] ch
	logic                  s_tlast = 1'b0;  // last
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [RES_DATA_W-1:0] m_tdata;         // [7:0] red, [15:8] green, [23:16] blue,
	                                        // [31:24] alpha, [33:32] status, rest zero

	color_string_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Parser shadow state
	form_t      form;
	logic [3:0] hex_pos;
	logic [7:0] comp [4];
	logic [2:0] tok_idx;
	logic [7:0] tok_val;
	logic [1:0] tok_ph;
	logic       neg;
	logic [3:0] high_nib;
	logic       parse_err;
	logic       tok_seen;

	result_t    pending_colors [$];
	logic [7:0] text_buf [$];
	int         mismatch_count = 0;
	int         chars_accepted = 0;
	int         idle_pct = 8;
	int         stall_pct = 8;

	function automatic result_t rgba_word(logic [1:0] st, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] a);
		result_t w;
		w.status = st;
		w.red = r;
		w.green = g;
		w.blue = b;
		w.alpha = a;
		return w;
	endfunction

	typedef struct {
		string   text;
		bit      typed;
		result_t col;
	} dir_row_t;

	// Directed strings; typed rows carry their known color, others go to the predictor
	dir_row_t dir_rows [16] = '{
		'{"x",                   1'b1, rgba_word(ST_FORM, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"#00",                 1'b1, rgba_word(ST_FORM, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"rgb",                 1'b1, rgba_word(ST_NUM, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"rgba",                1'b1, rgba_word(ST_NUM, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"rgb(",                1'b1, rgba_word(ST_OK, 8'd0, 8'd0, 8'd0, 8'd255)},
		'{"rgba(",               1'b1, rgba_word(ST_OK, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"#ff00ff",             1'b1, rgba_word(ST_OK, 8'd255, 8'd0, 8'd255, 8'd255)},
		'{"#FFFFFF00",           1'b1, rgba_word(ST_OK, 8'd255, 8'd255, 8'd255, 8'd0)},
		'{"rgb(255,0,128)",      1'b1, rgba_word(ST_OK, 8'd255, 8'd0, 8'd128, 8'd255)},
		'{"rgb(1,,3)",           1'b1, rgba_word(ST_NUM, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"Rgb(1,2,3)",          1'b1, rgba_word(ST_FORM, 8'd0, 8'd0, 8'd0, 8'd0)},
		'{"rgba( -1,+2 ,300,7)", 1'b0, '0},
		'{"rgb(1,2,3,4,5)",      1'b0, '0},
		'{"#-a+5\tG",            1'b0, '0},
		'{"rgb(-)",              1'b0, '0},
		'{"#12 3x4",             1'b0, '0}
	};

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - 48;
		if (c >= "a" && c <= "f") return int'(c) - 87;
		if (c >= "A" && c <= "F") return int'(c) - 55;
		return -1;
	endfunction

	function automatic void clear_token();
		tok_val = 8'd0;
		tok_ph = TP_LEAD;
		neg = 1'b0;
		tok_seen = 1'b0;
	endfunction

	function automatic void reset_parser();
		form = FM_START;
		hex_pos = 4'd0;
		foreach (comp[k]) comp[k] = 8'd0;
		tok_idx = 3'd0;
		high_nib = 4'd0;
		parse_err = 1'b0;
		clear_token();
	endfunction

	// Store a finished decimal token, or flag it when it held no digit
	function automatic void close_token(int lim);
		if (tok_idx < lim) begin
			if (tok_ph < TP_DIGITS) parse_err = 1'b1;
			else comp[tok_idx[1:0]] = neg ? 8'd0 - tok_val : tok_val;
		end
		if (tok_idx < 3'd7) tok_idx = tok_idx + 3'd1;
		clear_token();
	endfunction

	function automatic void dec_char(logic [7:0] c, int lim);
		bit digit;
		digit = c >= "0" && c <= "9";
		if (c == ",") begin
			close_token(lim);
			return;
		end
		tok_seen = 1'b1;
		if (tok_idx >= lim) return;
		case (tok_ph)
			TP_LEAD: begin
				if (!is_blank(c)) begin
					if (c == "+" || c == "-") begin
						neg = c == "-";
						tok_ph = TP_SIGN;
					end else if (digit) begin
						tok_val = c - 8'd48;
						tok_ph = TP_DIGITS;
					end else begin
						parse_err = 1'b1;
						tok_ph = TP_DONE;
					end
				end
			end
			TP_SIGN: begin
				if (digit) begin
					tok_val = c - 8'd48;
					tok_ph = TP_DIGITS;
				end else begin
					parse_err = 1'b1;
					tok_ph = TP_DONE;
				end
			end
			TP_DIGITS: begin
				if (digit) tok_val = tok_val * 8'd10 + (c - 8'd48);
				else tok_ph = TP_DONE;
			end
			default: ;
		endcase
	endfunction

	// Pair hex payload characters into components; count the payload length
	function automatic void hex_char(logic [7:0] c);
		logic [3:0] p;
		int         h;
		logic [7:0] v;
		p = hex_pos;
		if (hex_pos < 4'd15) hex_pos = hex_pos + 4'd1;
		if (p >= 4'd8) return;
		h = nibble_of(c);
		if (!p[0]) begin
			if (h >= 0) begin
				tok_ph = HX_HIGH;
				high_nib = h[3:0];
			end else if (is_blank(c) || c == "+") begin
				tok_ph = HX_PLAIN;
			end else if (c == "-") begin
				tok_ph = HX_NEG;
			end else begin
				tok_ph = HX_NONE;
				parse_err = 1'b1;
			end
			return;
		end
		v = 8'd0;
		case (tok_ph)
			HX_HIGH: v = (h >= 0) ? {high_nib, h[3:0]} : {4'd0, high_nib};
			HX_PLAIN: if (h >= 0) v = {4'd0, h[3:0]}; else parse_err = 1'b1;
			HX_NEG: if (h >= 0) v = 8'd0 - {4'd0, h[3:0]}; else parse_err = 1'b1;
			default: parse_err = 1'b1;
		endcase
		comp[p[2:1]] = v;
	endfunction

	// Advance the shadow parser by one character; return 1 with the color on the last one
	function automatic bit parse_char(input logic [7:0] c, input logic lst, output result_t col);
		logic [1:0] st;
		bit         fill;
		logic [7:0] a;
		int         lim;
		col = '0;
		if (!lst) begin
			case (form)
				FM_START: begin
					if (c == "#") form = FM_HEX;
					else if (c == "r") form = FM_R;
					else form = FM_BAD;
				end
				FM_R: form = (c == "g") ? FM_RG : FM_BAD;
				FM_RG: form = (c == "b") ? FM_RGB : FM_BAD;
				FM_RGB: form = (c == "a") ? FM_RGBA : FM_DEC3;
				FM_RGBA: form = FM_DEC4;
				FM_DEC3: dec_char(c, 3);
				FM_DEC4: dec_char(c, 4);
				FM_HEX: hex_char(c);
				default: ;
			endcase
			return 1'b0;
		end
		st = ST_FORM;
		fill = 1'b0;
		a = 8'd0;
		case (form)
			FM_RG: if (c == "b") st = ST_NUM;
			FM_RGB: begin
				if (c == "a") begin
					st = ST_NUM;
				end else begin
					st = ST_OK;
					a = 8'd255;
				end
			end
			FM_RGBA: st = ST_OK;
			FM_DEC3, FM_DEC4: begin
				lim = (form == FM_DEC3) ? 3 : 4;
				if (tok_seen) close_token(lim);
				if (parse_err) begin
					st = ST_NUM;
				end else begin
					st = ST_OK;
					fill = 1'b1;
					a = (lim == 3) ? 8'd255 : comp[3];
				end
			end
			FM_HEX: begin
				hex_char(c);
				if (hex_pos != 4'd6 && hex_pos != 4'd8) begin
					st = ST_FORM;
				end else if (parse_err) begin
					st = ST_NUM;
				end else begin
					st = ST_OK;
					fill = 1'b1;
					a = (hex_pos == 4'd6) ? 8'd255 : comp[3];
				end
			end
			default: ;
		endcase
		col.status = st;
		col.alpha = a;
		if (fill) begin
			col.red = comp[0];
			col.green = comp[1];
			col.blue = comp[2];
		end
		reset_parser();
		return 1'b1;
	endfunction

	initial reset_parser();

	// String generators, all appending to the text buffer

	function automatic void add_text(string s);
		foreach (s[k]) text_buf.push_back(s[k]);
	endfunction

	function automatic logic [7:0] blank_char();
		int n;
		n = $urandom_range(9, 14);
		return (n == 14) ? 8'd32 : 8'(n);
	endfunction

	function automatic void gen_token();
		int n;
		if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) text_buf.push_back(blank_char());
		case ($urandom_range(9))
			0: text_buf.push_back("-");
			1: text_buf.push_back("+");
			default: ;
		endcase
		n = ($urandom_range(15) == 0) ? $urandom_range(0, 5) : $urandom_range(1, 3);
		repeat (n) text_buf.push_back(8'(48 + $urandom_range(9)));
		// trailing junk that is not a comma
		if ($urandom_range(7) == 0) text_buf.push_back(8'($urandom_range(32, 43)));
	endfunction

	function automatic void gen_decimal_form(bit four);
		int n;
		add_text(four ? "rgba" : "rgb");
		if ($urandom_range(7) == 0) text_buf.push_back(8'($urandom_range(255)));
		else text_buf.push_back("(");
		n = ($urandom_range(7) == 0) ? $urandom_range(5) : (four ? 4 : 3);
		for (int k = 0; k < n; k++) begin
			if (k > 0) text_buf.push_back(",");
			gen_token();
		end
		if ($urandom_range(7) == 0) text_buf.push_back(8'($urandom_range(255)));
		else text_buf.push_back(")");
	endfunction

	function automatic void gen_hex_form();
		int n;
		int v;
		text_buf.push_back("#");
		case ($urandom_range(9))
			0: n = $urandom_range(0, 18);
			1, 2, 3, 4: n = 6;
			default: n = 8;
		endcase
		repeat (n) begin
			case ($urandom_range(19))
				0: text_buf.push_back(blank_char());
				1: text_buf.push_back("+");
				2: text_buf.push_back("-");
				3: text_buf.push_back(8'($urandom_range(255)));
				default: begin
					v = $urandom_range(15);
					if (v < 10) text_buf.push_back(8'(48 + v));
					else text_buf.push_back(8'(($urandom_range(1) ? 55 : 87) + v));
				end
			endcase
		end
	endfunction

	// Cut or corrupt an otherwise good string
	function automatic void gen_broken();
		int cut;
		if ($urandom_range(2) != 0) gen_decimal_form($urandom_range(1));
		else gen_hex_form();
		case ($urandom_range(2))
			0: begin
				cut = $urandom_range(1, text_buf.size());
				while (text_buf.size() > cut) void'(text_buf.pop_back());
			end
			1: text_buf[$urandom_range(text_buf.size() - 1)] = 8'($urandom_range(255));
			default: begin
				cut = $urandom_range(text_buf.size() < 4 ? text_buf.size() - 1 : 3);
				text_buf[cut] = text_buf[cut] ^ 8'h20;
			end
		endcase
	endfunction

	function automatic void gen_noise();
		repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(255)));
	endfunction

	// Send the buffered string, one word per character, last flagged on the final one
	task automatic send_text(input bit typed, input result_t typed_col);
		result_t col;
		bit      lst;
		for (int k = 0; k < text_buf.size(); k++) begin
			lst = k == text_buf.size() - 1;
			while ($urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata <= text_buf[k];
			s_tlast <= lst;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			if (parse_char(text_buf[k], lst, col)) pending_colors.push_back(typed ? typed_col : col);
			chars_accepted++;
		end
		text_buf.delete();
	endtask

	// Hold the input until every expected color has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int  kind;
		bit  paused;
		paused = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			add_text(dir_rows[i].text);
			send_text(dir_rows[i].typed, dir_rows[i].col);
		end
		drain();

		while (chars_accepted < TARGET_CHARS) begin
			// long stretch with no idling on either side
			if (chars_accepted >= 500 && chars_accepted < 900) begin
				idle_pct = 0;
				stall_pct = 0;
			end else begin
				idle_pct = 8;
				stall_pct = 8;
			end
			if (chars_accepted >= 1100 && !paused) begin
				drain();
				paused = 1'b1;
			end
			kind = $urandom_range(99);
			if (kind < 28) gen_decimal_form(1'b0);
			else if (kind < 54) gen_decimal_form(1'b1);
			else if (kind < 80) gen_hex_form();
			else if (kind < 92) gen_broken();
			else gen_noise();
			send_text(1'b0, '0);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Stall the output side at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Compare each color word with the oldest expected one
	always @(posedge clk) begin : check_colors
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(result_t)-1:0];
			if (pending_colors.size() == 0) begin
				$error("color word %h with no color expected", m_tdata);
				mismatch_count++;
			end else begin
				want = pending_colors.pop_front();
				check_field("red", want.red, got.red);
				check_field("green", want.green, got.green);
				check_field("blue", want.blue, got.blue);
				check_field("alpha", want.alpha, got.alpha);
				check_field("status", 8'(want.status), 8'(got.status));
				check_field("pad", 8'd0, 8'(m_tdata[RES_DATA_W-1:$bits(result_t)]));
			end
		end
	end

	initial begin : watchdog
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_in_stage.sv
hw/rtl/csp_core.sv
hw/rtl/csp_out_stage.sv
hw/rtl/color_string_parser_top.sv
hw/rtl/csp_checker.sv
bench/tb_color_string_parser_top.sv
